>>> hw/rtl/tdm_pkg.sv
// ----------------------------------------------------------------------------
// tdm_pkg
// Shared types and constants for the tank drive mixer with link watchdog.
// ----------------------------------------------------------------------------
`default_nettype none

package tdm_pkg;

  // Input word kinds (tuser low bits)
  typedef enum logic [1:0] {
    MODE_MESSAGE = 2'd0,
    MODE_TICK    = 2'd1,
    MODE_LINKERR = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_e;

  // Message kind byte
  localparam logic [7:0] KIND_DRIVE   = 8'h01;
  localparam logic [7:0] KIND_BUTTONS = 8'h02;

  // Motor direction codes
  typedef enum logic [1:0] {
    DIR_STOP    = 2'd0,
    DIR_FORWARD = 2'd1,
    DIR_REVERSE = 2'd2,
    DIR_BAD     = 2'd3
  } dir_e;

  // Configuration register indexes
  typedef enum logic [7:0] {
    REG_LINK_TIMEOUT = 8'd0,
    REG_DEAD_BAND    = 8'd1,
    REG_FIRE_ANGLE   = 8'd2,
    REG_REST_ANGLE   = 8'd3
  } reg_idx_e;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;

  // Register reset values
  localparam logic [7:0] LinkTimeoutRst = 8'd100;
  localparam logic [6:0] DeadBandRst    = 7'd10;
  localparam logic [7:0] FireAngleRst   = 8'd53;
  localparam logic [7:0] RestAngleRst   = 8'd70;

  // Mixing constants
  localparam logic [7:0] AxisCentre = 8'd100;
  localparam logic [6:0] AxisLimit  = 7'd100;
  localparam logic [7:0] SpeedBase  = 8'd60;
  localparam logic [7:0] TickMax    = 8'd255;

  // Port widths
  localparam int unsigned InDataW  = 24;  // 17 bits of fields, padded
  localparam int unsigned InUserW  = 10;
  localparam int unsigned OutDataW = 40;  // 39 bits of fields, padded

  // Packed result payload, last field in the lowest bits
  typedef struct packed {
    logic [0:0]        pad;
    logic              link_up;
    logic [7:0]        servo_angle;
    logic [7:0]        led_level;
    logic signed [8:0] left_level;
    logic [1:0]        left_dir;
    logic signed [8:0] right_level;
    logic [1:0]        right_dir;
  } out_data_t;

endpackage

`default_nettype wire

>>> hw/rtl/tank_drive_mixer_with_link_watchdog.sv
// ----------------------------------------------------------------------------
// tank_drive_mixer_with_link_watchdog
// Arcade-style differential drive mixer with trigger servo and link watchdog.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tuser: mode, message_kind
//                                            tdata: button_a, axis_forward,
//                                                   axis_turn
// m_axis    out  m_axis_tvalid/tready        tuser: drive_update
//                                            tdata: dirs, levels, led, servo,
//                                                   link_up
// cfg       in   cfg_valid/cfg_ready         cfg_index, cfg_data
//
// One word per cycle sustained while m_axis_tready_i is high. A word is held
// in the input register, is mixed by short logic and lands in the result
// register. The watchdog and trigger state update as the word leaves the
// input register. Ready propagates back from m_axis_tready_i, so a stall
// holds both registers without losing a word. Reset clears all control
// state and reloads the configuration defaults; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module tank_drive_mixer_with_link_watchdog
  import tdm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Input words
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // [0] button_a, [8:1] axis_forward, [16:9] axis_turn, [23:17] zero
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // [1:0] mode, [9:2] message_kind
  input  wire logic [InUserW-1:0]  s_axis_tuser_i,
  // Result words
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // [1:0] right_dir, [10:2] right_level, [12:11] left_dir,
  // [21:13] left_level, [29:22] led_level, [37:30] servo_angle,
  // [38] link_up, [39] zero
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  // [0] drive_update
  output logic                     m_axis_tuser_o,
  // Configuration writes
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  // --------------------------------------------------------------------------
  // Configuration registers: always ready, unknown indexes dropped
  // --------------------------------------------------------------------------
  logic [7:0] link_timeout_q;
  logic [6:0] dead_band_q;
  logic [7:0] fire_angle_q;
  logic [7:0] rest_angle_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_timeout_q <= LinkTimeoutRst;
      dead_band_q    <= DeadBandRst;
      fire_angle_q   <= FireAngleRst;
      rest_angle_q   <= RestAngleRst;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_LINK_TIMEOUT: link_timeout_q <= cfg_data_i;
        REG_DEAD_BAND:    dead_band_q    <= cfg_data_i[6:0];
        REG_FIRE_ANGLE:   fire_angle_q   <= cfg_data_i;
        REG_REST_ANGLE:   rest_angle_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic       in_valid_q;
  mode_e      in_mode_q;
  logic [7:0] in_kind_q;
  logic       in_btn_q;
  logic [7:0] in_fwd_q;
  logic [7:0] in_trn_q;

  logic out_valid_q;
  logic out_free;
  logic advance;
  logic in_accept;

  // Result register can take a word when empty or being drained this cycle
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_mode_q <= mode_e'(s_axis_tuser_i[1:0]);
      in_kind_q <= s_axis_tuser_i[9:2];
      in_btn_q  <= s_axis_tdata_i[0];
      in_fwd_q  <= s_axis_tdata_i[8:1];
      in_trn_q  <= s_axis_tdata_i[16:9];
    end
  end

  // --------------------------------------------------------------------------
  // Mixing: axes as sign plus clamped magnitude
  // --------------------------------------------------------------------------
  logic        v_neg;
  logic [6:0]  v_mag;
  logic        t_left;
  logic        t_nz;
  logic [6:0]  t_mag;
  logic [7:0]  fwd_hi;
  logic [7:0]  trn_hi;
  logic [9:0]  speed_prod;     // |v| * 7, at most 700
  logic [10:0] turn_prod;      // |t| * 13, at most 1300
  logic [23:0] speed_recip;
  logic [23:0] turn_recip;
  logic [7:0]  speed;          // 60 .. 200
  logic [7:0]  turn;           // 0 .. 130
  logic signed [8:0] lvl_full;
  logic signed [8:0] lvl_less;
  logic signed [8:0] lvl_pivot;
  logic        go_fwd;
  logic        go_rev;
  logic        go_pivot;

  always_comb begin
    fwd_hi = in_fwd_q - AxisCentre;
    trn_hi = in_trn_q - AxisCentre;

    // Throttle: above centre positive, clamp at the limit
    v_neg = in_fwd_q < AxisCentre;
    if (v_neg) begin
      v_mag = 7'(AxisCentre - in_fwd_q);
    end else if (fwd_hi > {1'b0, AxisLimit}) begin
      v_mag = AxisLimit;
    end else begin
      v_mag = fwd_hi[6:0];
    end

    // Turn: above centre means left
    t_left = in_trn_q > AxisCentre;
    t_nz   = in_trn_q != AxisCentre;
    if (!t_left) begin
      t_mag = 7'(AxisCentre - in_trn_q);
    end else if (trn_hi > {1'b0, AxisLimit}) begin
      t_mag = AxisLimit;
    end else begin
      t_mag = trn_hi[6:0];
    end
  end

  // |v|*140/100 = |v|*7/5 and |t|*130/100 = |t|*13/10, divide by reciprocal
  // (13108/2^16 for a fifth, 6554/2^16 for a tenth; exact over these ranges)
  assign speed_prod  = {3'b0, v_mag} * 10'd7;
  assign turn_prod   = {4'b0, t_mag} * 11'd13;
  assign speed_recip = {14'b0, speed_prod} * 24'd13108;
  assign turn_recip  = {13'b0, turn_prod} * 24'd6554;
  assign speed       = speed_recip[23:16] + SpeedBase;
  assign turn        = turn_recip[23:16];

  assign lvl_full  = $signed({1'b0, speed});
  assign lvl_less  = $signed({1'b0, speed}) - $signed({1'b0, turn});
  assign lvl_pivot = $signed({1'b0, turn + SpeedBase});

  assign go_fwd   = !v_neg && (v_mag > dead_band_q);
  assign go_rev   = v_neg && (v_mag > dead_band_q);
  assign go_pivot = (v_mag < dead_band_q) && t_nz;

  // --------------------------------------------------------------------------
  // Watchdog, trigger and result selection
  // --------------------------------------------------------------------------
  logic [7:0] ticks_q, ticks_d, ticks_inc;
  logic       fire_armed_q, fire_armed_d;
  logic       link_q, link_d;
  logic [7:0] servo_q, servo_d;
  logic       update;
  out_data_t  res;

  assign ticks_inc = (ticks_q == TickMax) ? ticks_q : ticks_q + 8'd1;

  always_comb begin
    ticks_d      = ticks_q;
    fire_armed_d = fire_armed_q;
    link_d       = link_q;
    servo_d      = servo_q;
    update       = 1'b0;
    res          = '0;

    case (in_mode_q)
      MODE_MESSAGE: begin
        ticks_d = '0;
        if (in_kind_q == KIND_BUTTONS && in_btn_q) begin
          fire_armed_d = 1'b1;
        end
        if (in_kind_q == KIND_DRIVE) begin
          link_d = 1'b1;
          update = 1'b1;
          if (go_fwd || go_rev) begin
            res.right_dir   = go_fwd ? DIR_FORWARD : DIR_REVERSE;
            res.left_dir    = go_fwd ? DIR_FORWARD : DIR_REVERSE;
            res.right_level = t_left ? lvl_full : lvl_less;
            res.left_level  = t_left ? lvl_less : lvl_full;
            res.led_level   = {1'b0, v_mag};
          end else if (go_pivot) begin
            res.right_dir   = t_left ? DIR_FORWARD : DIR_REVERSE;
            res.left_dir    = t_left ? DIR_REVERSE : DIR_FORWARD;
            res.right_level = lvl_pivot;
            res.left_level  = lvl_pivot;
            res.led_level   = turn;
          end
        end
      end
      MODE_TICK: begin
        // Show the fire angle once after arming, else the rest angle
        if (fire_armed_q) begin
          servo_d      = fire_angle_q;
          fire_armed_d = 1'b0;
        end else begin
          servo_d = rest_angle_q;
        end
        ticks_d = ticks_inc;
        if (ticks_inc > link_timeout_q) begin
          link_d = 1'b0;
          update = 1'b1;   // stop
        end
      end
      MODE_LINKERR: begin
        update = 1'b1;     // stop, link flag kept
      end
      default: ;
    endcase

    res.servo_angle = servo_d;
    res.link_up     = link_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q      <= '0;
      fire_armed_q <= 1'b0;
      link_q       <= 1'b0;
      servo_q      <= RestAngleRst;
    end else if (advance) begin
      ticks_q      <= ticks_d;
      fire_armed_q <= fire_armed_d;
      link_q       <= link_d;
      servo_q      <= servo_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  out_data_t out_data_q;
  logic      out_upd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= res;
      out_upd_q  <= update;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_upd_q;

endmodule

`default_nettype wire

>>> hw/rtl/tdm_checker.sv
// ----------------------------------------------------------------------------
// tdm_checker
// Port-level checks for the tank drive mixer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tdm_checker
  import tdm_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                m_axis_tvalid_o,
  input wire logic                m_axis_tready_i,
  input wire logic [OutDataW-1:0] m_axis_tdata_o,
  input wire logic                m_axis_tuser_o
);

  out_data_t d;
  assign d = m_axis_tdata_o;

  // Hold a stalled result word
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result word changed while stalled");

  // Without an update the motor and led fields are zero
  a_no_update_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |->
      d.right_dir == DIR_STOP && d.left_dir == DIR_STOP &&
      d.right_level == '0 && d.left_level == '0 && d.led_level == '0)
    else $error("motor fields set without drive update");

  // A stopped side means both sides stopped, levels and led zero
  a_stop_whole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (d.right_dir == DIR_STOP || d.left_dir == DIR_STOP) |->
      d.right_dir == d.left_dir && d.right_level == '0 &&
      d.left_level == '0 && d.led_level == '0)
    else $error("partial stop");

  // Pivot runs the sides opposite at equal level
  a_pivot_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && d.right_dir != DIR_STOP && d.right_dir != d.left_dir |->
      d.right_level == d.left_level)
    else $error("pivot levels differ");

endmodule

bind tank_drive_mixer_with_link_watchdog tdm_checker u_tdm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);

`default_nettype wire
